// File: design/life_like_automaton_stencil_defines.svh
// ----------------------------------------------------------------------------
// Life-like automaton stencil assertion macros
// Shorthand for the concurrent checks used by the stencil checker.
// ----------------------------------------------------------------------------
`ifndef LIFE_LIKE_AUTOMATON_STENCIL_DEFINES_SVH
`define LIFE_LIKE_AUTOMATON_STENCIL_DEFINES_SVH

// Check that is switched off while reset is high.
`define LLA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that also holds across reset.
`define LLA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/lla_pkg.sv
// ----------------------------------------------------------------------------
// Life-like automaton stencil package
// Payload types, register codes, reset values and the size clamp helper.
// ----------------------------------------------------------------------------
package lla_pkg;

   localparam int CSR_DATA_WIDTH   = 9;
   localparam int COUNT_WIDTH      = 4;
   localparam int COORD_WIDTH      = 8;
   localparam int MIN_SIZE         = 3;
   localparam int RESET_ROW_LENGTH = 200;
   localparam int RESET_ROWS       = 200;
   localparam logic [COUNT_WIDTH-1:0] RESET_COUNT_LOW  = 4'd3;
   localparam logic [COUNT_WIDTH-1:0] RESET_COUNT_HIGH = 4'd5;

   // Request payload: one cell of the current generation.
   typedef struct packed {
      logic cell_alive;
      logic frame_start;
   } lla_req_type;

   // Response payload: one cell of the next generation.
   typedef struct packed {
      logic                   next_alive;
      logic [COORD_WIDTH-1:0] out_row;
      logic [COORD_WIDTH-1:0] out_col;
      logic                   frame_done;
   } lla_rsp_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_ROW_LENGTH  = 2'd0,
      CSR_ROWS_IN_USE = 2'd1,
      CSR_COUNT_LOW   = 2'd2,
      CSR_COUNT_HIGH  = 2'd3
   } lla_csr_type;

   // Per-cell information worked out when the request is taken.
   typedef struct packed {
      logic                   emit;
      logic                   interior;
      logic                   frame_done;
      logic                   alive;
      logic [COORD_WIDTH-1:0] out_row;
      logic [COORD_WIDTH-1:0] out_col;
   } lla_tag_type;

   // Limits a grid size to the range from the minimum up to hi.
   function automatic int lla_clamp(input logic [CSR_DATA_WIDTH-1:0] value, input int hi);
      int v;
      v = int'(value);
      if (v < MIN_SIZE) begin
         return MIN_SIZE;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

endpackage

// File: design/lla_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid and ready handshake carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface lla_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// File: design/life_like_automaton_stencil.sv
// ----------------------------------------------------------------------------
// Life-like automaton stencil
// One cell per cycle unless stalled; next-generation cells leave by a register.
// ----------------------------------------------------------------------------
// The block takes one cell per cycle in raster order unless a stalled response
// holds it off, and returns the next generation of the cell one row and one
// column behind it through the window stage register and then the response
// register. The window stage sits behind the registered read port of the line
// buffer memory, which holds both rows above the input in one word per column.
// Border cells keep their state; interior cells live when their live neighbors
// lie between count_low and count_high. The first row_length+1 cells of a frame
// give no result; the last row_length+1 cells are never returned. Line buffer
// contents need no clearing after reset. Write configuration only while idle.
module life_like_automaton_stencil #(
   parameter int MAX_ROW_LENGTH = 256,
   parameter int MAX_ROWS       = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lla_stream_if.sink                            req_ch,
   lla_stream_if.source                          rsp_ch,
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [lla_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int COL_W = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W = $clog2(MAX_ROW_LENGTH+1);
   localparam int HGT_W = $clog2(MAX_ROWS+1);

   logic [LEN_W-1:0] row_len_ff, row_len_in;
   logic [HGT_W-1:0] rows_ff, rows_in;
   logic [lla_pkg::COUNT_WIDTH-1:0] count_low_ff, count_low_in;
   logic [lla_pkg::COUNT_WIDTH-1:0] count_high_ff, count_high_in;

   logic                 accept, a_adv;
   logic                 a_valid_ff, a_valid_in;
   lla_pkg::lla_tag_type tag, a_tag_ff;
   logic [COL_W-1:0]     col, a_col_ff;
   logic                 top, mid, live;
   logic                 rsp_valid_ff, rsp_valid_in;
   lla_pkg::lla_rsp_type rsp_data_ff, rsp_data_in;

   // Configuration registers; sizes are clamped when written.
   always_comb begin
      row_len_in    = row_len_ff;
      rows_in       = rows_ff;
      count_low_in  = count_low_ff;
      count_high_in = count_high_ff;
      if (csr_we) begin
         unique case (lla_pkg::lla_csr_type'(csr_index))
            lla_pkg::CSR_ROW_LENGTH:
               row_len_in = LEN_W'(lla_pkg::lla_clamp(csr_wdata, MAX_ROW_LENGTH));
            lla_pkg::CSR_ROWS_IN_USE:
               rows_in = HGT_W'(lla_pkg::lla_clamp(csr_wdata, MAX_ROWS));
            lla_pkg::CSR_COUNT_LOW:
               count_low_in = csr_wdata[lla_pkg::COUNT_WIDTH-1:0];
            lla_pkg::CSR_COUNT_HIGH:
               count_high_in = csr_wdata[lla_pkg::COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_len_ff    <= LEN_W'(lla_pkg::lla_clamp(
                             lla_pkg::CSR_DATA_WIDTH'(lla_pkg::RESET_ROW_LENGTH), MAX_ROW_LENGTH));
         rows_ff       <= HGT_W'(lla_pkg::lla_clamp(
                             lla_pkg::CSR_DATA_WIDTH'(lla_pkg::RESET_ROWS), MAX_ROWS));
         count_low_ff  <= lla_pkg::RESET_COUNT_LOW;
         count_high_ff <= lla_pkg::RESET_COUNT_HIGH;
      end else begin
         row_len_ff    <= row_len_in;
         rows_ff       <= rows_in;
         count_low_ff  <= count_low_in;
         count_high_ff <= count_high_in;
      end
   end

   // Handshake: the window stage moves on unless its result has nowhere to go.
   assign accept        = req_ch.valid && req_ch.ready;
   assign a_adv         = a_valid_ff && (!a_tag_ff.emit || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !reset && (!a_valid_ff || a_adv);

   lla_position #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
      .MAX_ROWS       (MAX_ROWS)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cell_alive  (req_ch.payload.cell_alive),
      .frame_start (req_ch.payload.frame_start),
      .row_len     (row_len_ff),
      .rows        (rows_ff),
      .col         (col),
      .tag         (tag)
   );

   lla_line_buf #(
      .DEPTH (MAX_ROW_LENGTH)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col),
      .wr_en   (a_adv),
      .wr_addr (a_col_ff),
      .new_bit (a_tag_ff.alive),
      .top     (top),
      .mid     (mid)
   );

   // Window stage register.
   assign a_valid_in = accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_tag_ff <= tag;
         a_col_ff <= col;
      end
   end

   lla_window u_window (
      .clock      (clock),
      .reset      (reset),
      .adv        (a_adv),
      .top        (top),
      .mid        (mid),
      .new_bit    (a_tag_ff.alive),
      .interior   (a_tag_ff.interior),
      .count_low  (count_low_ff),
      .count_high (count_high_ff),
      .live       (live)
   );

   // Response register.
   always_comb begin
      rsp_data_in.next_alive = live;
      rsp_data_in.out_row    = a_tag_ff.out_row;
      rsp_data_in.out_col    = a_tag_ff.out_col;
      rsp_data_in.frame_done = a_tag_ff.frame_done;
      if (a_adv && a_tag_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && a_tag_ff.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule

// File: design/lla_position.sv
// ----------------------------------------------------------------------------
// Raster position tracker
// Keeps the row and column of the next cell and derives where its result goes.
// ----------------------------------------------------------------------------
module lla_position #(
   parameter int MAX_ROW_LENGTH = 256,
   parameter int MAX_ROWS       = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 cell_alive,
   input  logic                                 frame_start,
   input  logic [$clog2(MAX_ROW_LENGTH+1)-1:0]  row_len,
   input  logic [$clog2(MAX_ROWS+1)-1:0]        rows,
   output logic [$clog2(MAX_ROW_LENGTH)-1:0]    col,
   output lla_pkg::lla_tag_type                 tag
);

   localparam int COL_W = $clog2(MAX_ROW_LENGTH);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int LEN_W = $clog2(MAX_ROW_LENGTH+1);
   localparam int HGT_W = $clog2(MAX_ROWS+1);

   logic [COL_W-1:0] col_ff, col_in, cur_col, ex_col;
   logic [ROW_W-1:0] row_ff, row_in, cur_row, ex_row;
   logic             restart, last_col, last_row;

   // A frame marker or a position left outside the grid restarts at the origin.
   always_comb begin
      restart  = frame_start || (LEN_W'(col_ff) >= row_len) || (HGT_W'(row_ff) >= rows);
      cur_col  = restart ? '0 : col_ff;
      cur_row  = restart ? '0 : row_ff;
      last_col = (LEN_W'(cur_col) + LEN_W'(1)) >= row_len;
      last_row = (HGT_W'(cur_row) + HGT_W'(1)) >= rows;
   end

   // Raster advance with wrap at the end of a row and of the frame.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = last_col ? '0 : cur_col + COL_W'(1);
         if (last_col) begin
            row_in = last_row ? '0 : cur_row + ROW_W'(1);
         end else begin
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // The result belongs to the cell one row and one column behind the input.
   always_comb begin
      if (cur_col != '0) begin
         ex_row = cur_row - ROW_W'(1);
         ex_col = cur_col - COL_W'(1);
      end else begin
         ex_row = cur_row - ROW_W'(2);
         ex_col = COL_W'(row_len - LEN_W'(1));
      end
   end

   // Result tag for this cell.
   always_comb begin
      tag.emit       = (cur_row >= ROW_W'(2)) || ((cur_row == ROW_W'(1)) && (cur_col != '0));
      tag.interior   = (ex_row != '0) && (HGT_W'(ex_row) < rows - HGT_W'(1)) &&
                       (ex_col != '0) && (LEN_W'(ex_col) < row_len - LEN_W'(1));
      tag.frame_done = last_row && last_col;
      tag.alive      = cell_alive;
      tag.out_row    = lla_pkg::COORD_WIDTH'(ex_row);
      tag.out_col    = lla_pkg::COORD_WIDTH'(ex_col);
      col            = cur_col;
   end

endmodule

// File: design/lla_line_buf.sv
// ----------------------------------------------------------------------------
// Two-row line buffer
// One memory word per column holds the cells of the two rows above the input.
// ----------------------------------------------------------------------------
module lla_line_buf #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic                     new_bit,
   output logic                     top,
   output logic                     mid
);

   localparam int ADDR_W = $clog2(DEPTH);

   // Bit 1 is the upper row, bit 0 the middle row.
   logic [1:0] line_mem [DEPTH];
   logic [1:0] rd_data_ff;
   logic [1:0] fwd_data_ff, fwd_data_in;
   logic       fwd_ff, fwd_in;
   logic [1:0] word;

   // The middle cell moves up and the new cell takes its place.
   assign fwd_data_in = {mid, new_bit};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= fwd_data_in;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   // A read of the column being written in the same cycle takes the new word.
   assign fwd_in = rd_en ? (wr_en && (wr_addr == ADDR_W'(rd_addr))) : fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= fwd_data_in;
      end
   end

   assign word = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign top  = word[1];
   assign mid  = word[0];

endmodule

// File: design/lla_window.sv
// ----------------------------------------------------------------------------
// Stencil window and rule
// Holds the 3x3 window and applies the neighbor count rule to its center.
// ----------------------------------------------------------------------------
module lla_window (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                top,
   input  logic                                mid,
   input  logic                                new_bit,
   input  logic                                interior,
   input  logic [lla_pkg::COUNT_WIDTH-1:0]     count_low,
   input  logic [lla_pkg::COUNT_WIDTH-1:0]     count_high,
   output logic                                live
);

   logic [8:0] window_ff, window_in;
   logic [8:0] shifted;
   logic [lla_pkg::COUNT_WIDTH-1:0] count;

   // Each window row shifts by one column; bit 0 of a row is the newest column.
   assign shifted = {window_ff[7:6], top, window_ff[4:3], mid, window_ff[1:0], new_bit};
   assign window_in = adv ? shifted : window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // Live neighbors: every window bit but the center.
   always_comb begin
      count = '0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            count = count + lla_pkg::COUNT_WIDTH'(shifted[i]);
         end
      end
   end

   // Interior cells follow the rule; border cells keep their state.
   assign live = interior ? ((count >= count_low) && (count <= count_high)) : shifted[4];

endmodule

// File: design/lla_checker.sv
// ----------------------------------------------------------------------------
// Life-like automaton stencil checker
// Port-level checks on the stencil, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "life_like_automaton_stencil_defines.svh"

module lla_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input lla_pkg::lla_rsp_type rsp_payload
);

   // Reset empties the response register.
   `LLA_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "response valid after reset")

   // A waiting response keeps its value.
   `LLA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled response changed")

   // Requests are only held off by a stalled response.
   `LLA_ASSERT(a_ready_cause, !req_ready |-> rsp_valid && !rsp_ready, "request stalled without back pressure")

   // A fresh response must come from a taken request.
   `LLA_ASSERT(a_rsp_origin, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "response without request")

endmodule

bind life_like_automaton_stencil lla_checker u_lla_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

// File: test/life_like_automaton_stencil_test.sv
// ----------------------------------------------------------------------------
// Life-like automaton stencil testbench
// Streams cell frames of many grid sizes and survival ranges into the stencil,
// with random gaps on the request side and random stalls on the response side.
// A local model of the line buffers and window predicts every next-generation
// cell, and each response is checked field by field against it.
// ----------------------------------------------------------------------------
module life_like_automaton_stencil_test;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_LIMIT = 40;

   // One pending request, optionally held back until all responses are in.
   typedef struct {
      lla_pkg::lla_req_type payload;
      bit                   hold_for_drain;
   } queued_cell_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_we;
   logic [1:0]                         csr_index;
   logic [lla_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;

   lla_stream_if #(.payload_type(lla_pkg::lla_req_type)) req_if ();
   lla_stream_if #(.payload_type(lla_pkg::lla_rsp_type)) rsp_if ();

   life_like_automaton_stencil #(
      .MAX_ROW_LENGTH(MAX_WIDTH),
      .MAX_ROWS(MAX_HEIGHT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   queued_cell_type      pending_cells[$];
   lla_pkg::lla_rsp_type predicted_cells[$];

   // Shadow copy of the rule registers.
   logic [8:0] grid_width_setting;
   logic [8:0] grid_rows_setting;
   logic [3:0] live_count_min;
   logic [3:0] live_count_max;

   // Shadow copy of the stencil state.
   logic       upper_row_buf [MAX_WIDTH];
   logic       middle_row_buf [MAX_WIDTH];
   logic [8:0] stencil_window;
   int unsigned cur_row;
   int unsigned cur_col;

   int unsigned send_gap;
   int unsigned take_stall;
   bit          send_calm = 1'b0;
   bit          take_calm = 1'b0;
   int unsigned cells_sent = 0;
   int unsigned results_checked = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Grid sizes outside the legal range fall back to the nearest limit.
   function automatic int unsigned effective_size(input logic [8:0] raw, input int unsigned hi);
      if (raw < 3) begin
         return 3;
      end
      if (raw > hi) begin
         return hi;
      end
      return 32'(raw);
   endfunction

   function automatic int unsigned draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 13);
   endfunction

   task automatic reset_generation_state();
      grid_width_setting = 9'(lla_pkg::RESET_ROW_LENGTH);
      grid_rows_setting = 9'(lla_pkg::RESET_ROWS);
      live_count_min = lla_pkg::RESET_COUNT_LOW;
      live_count_max = lla_pkg::RESET_COUNT_HIGH;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_row_buf[i] = 1'b0;
         middle_row_buf[i] = 1'b0;
      end
      stencil_window = '0;
      cur_row = 0;
      cur_col = 0;
   endtask

   // Takes one incoming cell and works out the next-generation cell that
   // leaves one row and one column behind it, if any.
   function automatic bit next_generation(input lla_pkg::lla_req_type incoming,
                                          output lla_pkg::lla_rsp_type predicted);
      int unsigned w, h, r, c, er, ec, neighbors;
      logic top, mid, centre;
      bit interior, live, emitted;
      w = effective_size(grid_width_setting, MAX_WIDTH);
      h = effective_size(grid_rows_setting, MAX_HEIGHT);
      predicted = '0;
      emitted = 1'b0;

      // A marker, or a position left outside the grid, restarts at the corner.
      if (incoming.frame_start || cur_col >= w || cur_row >= h) begin
         cur_row = 0;
         cur_col = 0;
      end
      r = cur_row;
      c = cur_col;

      // Line buffers shift up one row at this column.
      top = upper_row_buf[c[7:0]];
      mid = middle_row_buf[c[7:0]];
      upper_row_buf[c[7:0]] = mid;
      middle_row_buf[c[7:0]] = incoming.cell_alive;

      // Each window row shifts left, the newest column enters at the bottom bit.
      stencil_window = {stencil_window[7:6], top, stencil_window[4:3], mid,
                        stencil_window[1:0], incoming.cell_alive};
      centre = stencil_window[4];
      neighbors = $countones(stencil_window) - centre;

      if (r >= 2 || (r == 1 && c >= 1)) begin
         if (c != 0) begin
            er = r - 1;
            ec = c - 1;
         end else begin
            er = r - 2;
            ec = w - 1;
         end
         interior = er >= 1 && er + 2 <= h && ec >= 1 && ec + 2 <= w;
         if (interior) begin
            live = neighbors >= live_count_min && neighbors <= live_count_max;
         end else begin
            live = centre;
         end
         predicted.next_alive = live;
         predicted.out_row = er[7:0];
         predicted.out_col = ec[7:0];
         predicted.frame_done = (r == h - 1 && c == w - 1);
         emitted = 1'b1;
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) begin
            r = 0;
         end
      end
      cur_row = r;
      cur_col = c;
      return emitted;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("%0t: mismatch on %s in response %0d: got %0d, expected %0d",
                  $time, what, results_checked, got, want);
      end
   endtask

   // Request driver: presents queued cells with random gaps between them.
   always @(posedge clock) begin : driver
      queued_cell_type next_cell;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.payload <= '0;
         send_gap <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap != 0) begin
            req_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_cells.size() != 0 &&
                      !(pending_cells[0].hold_for_drain &&
                        (req_if.valid || predicted_cells.size() != 0))) begin
            next_cell = pending_cells.pop_front();
            req_if.valid <= 1'b1;
            req_if.payload <= next_cell.payload;
            send_gap <= draw_wait(send_calm);
            cells_sent++;
            if (cells_sent % 50 == 0) begin
               send_calm = ($urandom_range(0, 2) == 0);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response monitor: stalls at random, checks responses, predicts them from taken requests.
   always @(posedge clock) begin : monitor
      lla_pkg::lla_rsp_type got_cell;
      lla_pkg::lla_rsp_type want_cell;
      int unsigned stall;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_stall <= 0;
         reset_generation_state();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got_cell = rsp_if.payload;
            if (predicted_cells.size() == 0) begin
               report_mismatch("unexpected response", got_cell.out_row, 8'd0);
            end else begin
               want_cell = predicted_cells.pop_front();
               if (got_cell.next_alive !== want_cell.next_alive) begin
                  report_mismatch("next_alive", 8'(got_cell.next_alive),
                                  8'(want_cell.next_alive));
               end
               if (got_cell.out_row !== want_cell.out_row) begin
                  report_mismatch("out_row", got_cell.out_row, want_cell.out_row);
               end
               if (got_cell.out_col !== want_cell.out_col) begin
                  report_mismatch("out_col", got_cell.out_col, want_cell.out_col);
               end
               if (got_cell.frame_done !== want_cell.frame_done) begin
                  report_mismatch("frame_done", 8'(got_cell.frame_done),
                                  8'(want_cell.frame_done));
               end
            end
            results_checked++;
            if (results_checked % 40 == 0) begin
               take_calm = ($urandom_range(0, 2) == 0);
            end
            stall = draw_wait(take_calm);
            take_stall <= stall;
            rsp_if.ready <= (stall == 0);
         end else if (take_stall != 0) begin
            take_stall <= take_stall - 1;
            rsp_if.ready <= (take_stall == 1);
         end else begin
            rsp_if.ready <= 1'b1;
         end

         if (req_if.valid && req_if.ready) begin
            if (next_generation(req_if.payload, want_cell)) begin
               predicted_cells.push_back(want_cell);
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || csr_we || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Waits until every request is taken and every response has come back,
   // then lets the pipeline drain cells that give no response.
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_cells.size() != 0 || req_if.valid || predicted_cells.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input lla_pkg::lla_csr_type index, input logic [8:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         lla_pkg::CSR_ROW_LENGTH: begin
            grid_width_setting = value;
         end
         lla_pkg::CSR_ROWS_IN_USE: begin
            grid_rows_setting = value;
         end
         lla_pkg::CSR_COUNT_LOW: begin
            live_count_min = value[3:0];
         end
         lla_pkg::CSR_COUNT_HIGH: begin
            live_count_max = value[3:0];
         end
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_rules(input logic [8:0] width_raw, input logic [8:0] rows_raw,
                            input logic [8:0] low_word, input logic [8:0] high_word);
      write_register(lla_pkg::CSR_ROW_LENGTH, width_raw);
      write_register(lla_pkg::CSR_ROWS_IN_USE, rows_raw);
      write_register(lla_pkg::CSR_COUNT_LOW, low_word);
      write_register(lla_pkg::CSR_COUNT_HIGH, high_word);
      @(negedge clock);
   endtask

   task automatic push_cell(input logic alive, input logic start);
      queued_cell_type item;
      item.payload.cell_alive = alive;
      item.payload.frame_start = start;
      item.hold_for_drain = 1'b0;
      pending_cells.push_back(item);
   endtask

   // Queues whole frames of random cells, mostly marked on their first cell,
   // with the odd cut-short frame and stray marker mixed in. Runs of uncut
   // frames always mark their first frame, so a wider grid never picks up
   // mid-frame over columns that were never filled.
   task automatic queue_random_frames(input int unsigned total, input int unsigned frame_len,
                                      input bit allow_cut);
      queued_cell_type item;
      int unsigned queued, len, density;
      bit marked;
      queued = 0;
      while (queued < total) begin
         len = frame_len;
         if (allow_cut && $urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, frame_len - 1);
         end
         marked = (queued == 0) ? (!allow_cut || ($urandom_range(0, 1) != 0)) :
                                  ($urandom_range(0, 3) != 0);
         density = 5 + 22 * $urandom_range(0, 4);
         for (int i = 0; i < len && queued < total; i++) begin
            item.payload.cell_alive = ($urandom_range(0, 99) < density);
            item.payload.frame_start = (i == 0 && marked) || ($urandom_range(0, 299) == 0);
            item.hold_for_drain = ($urandom_range(0, 249) == 0);
            pending_cells.push_back(item);
            queued++;
         end
      end
   endtask

   initial begin : stimulus
      logic [8:0] width_raw;
      logic [8:0] rows_raw;
      logic [3:0] low_count;
      logic [3:0] high_count;
      logic [4:0] junk_low;
      logic [4:0] junk_high;
      int unsigned a, b, phase, small_cells, cells, width_eff, rows_eff;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = lla_pkg::CSR_ROW_LENGTH;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // Smallest grid, all live cells, survival only at eight neighbors.
      set_rules(9'd3, 9'd3, 9'd8, 9'd8);
      for (int i = 0; i < 9; i++) begin
         push_cell(1'b1, i == 0);
      end
      wait_idle();

      // All dead cells with no marker: the position wraps from the last frame,
      // and a lone interior cell comes alive with zero neighbors.
      set_rules(9'd3, 9'd3, 9'd0, 9'd0);
      for (int i = 0; i < 9; i++) begin
         push_cell(1'b0, 1'b0);
      end
      wait_idle();

      // Clamped sizes, an empty survival range and a marker mid-frame.
      set_rules(9'd0, 9'd1, 9'h1F9, 9'd8);
      push_cell(1'b1, 1'b0);
      for (int i = 0; i < 9; i++) begin
         push_cell(1'b1, i == 0);
      end

      // Random phases, mostly on small grids with a few at the size limits.
      phase = 0;
      small_cells = 0;
      while (phase < 6 || small_cells < 200) begin
         wait_idle();
         case (phase)
            1: begin
               width_raw = 9'd256;
               rows_raw = 9'd3;
            end
            3: begin
               width_raw = 9'd2;
               rows_raw = 9'h1FF;
            end
            default: begin
               width_raw = 9'($urandom_range(3, 12));
               rows_raw = 9'($urandom_range(3, 10));
               if ($urandom_range(0, 5) == 0) begin
                  width_raw = 9'($urandom_range(0, 2));
               end
               if ($urandom_range(0, 5) == 0) begin
                  rows_raw = 9'($urandom_range(0, 2));
               end
            end
         endcase
         if ($urandom_range(0, 3) == 0) begin
            low_count = 4'($urandom_range(0, 15));
            high_count = 4'($urandom_range(0, 15));
         end else begin
            a = $urandom_range(0, 8);
            b = $urandom_range(0, 8);
            low_count = 4'((a < b) ? a : b);
            high_count = 4'((a < b) ? b : a);
         end
         if (phase == 0) begin
            low_count = 4'd0;
            high_count = 4'd8;
         end
         junk_low = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 31)) : 5'd0;
         junk_high = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 31)) : 5'd0;
         set_rules(width_raw, rows_raw, {junk_low, low_count}, {junk_high, high_count});

         width_eff = effective_size(width_raw, MAX_WIDTH);
         rows_eff = effective_size(rows_raw, MAX_HEIGHT);
         if (phase == 1) begin
            queue_random_frames(width_eff * rows_eff, width_eff * rows_eff, 1'b0);
         end else if (phase == 3) begin
            // Part of a tall frame, so the rows run past every small grid
            // and the next phase starts from a position outside its grid.
            queue_random_frames(60, width_eff * rows_eff, 1'b0);
         end else begin
            cells = $urandom_range(1, 2) * width_eff * rows_eff;
            queue_random_frames(cells, width_eff * rows_eff, 1'b1);
            small_cells += cells;
         end
         phase++;
      end

      wait_idle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
